>>> sv/ttw_pkg.sv
// Package for the text terminal writer: field widths, operation and character
// codes, the cell layout and the controller state type.
// No dependencies; every other file of the block imports it.
package ttw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_DEFAULT = 8'h07;

  typedef struct packed {
    logic [CHAR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  localparam cell_t BLANK_CELL = '{attr: ATTR_DEFAULT, chr: CH_SPACE};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_PUT  = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

endpackage

>>> sv/ttw_if.sv
// Channel interfaces of the text terminal writer: the request channel and the
// result channel, each with valid/ready handshake. Depends on ttw_pkg.
interface ttw_in_if import ttw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] character;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, operation, character, read_row, read_col, input ready);
  modport sink   (input valid, operation, character, read_row, read_col, output ready);
endinterface

interface ttw_out_if import ttw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  modport source (output valid, cell_char, cell_attr, cursor_row, cursor_col, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_row, cursor_col, output ready);
endinterface

>>> sv/text_terminal_writer.sv
// Top level of the text terminal writer: cursor and scroll control around the
// screen cell store. Depends on ttw_pkg, ttw_if and ttw_cell_mem.
//
// Usage: each request on in_ch carries an operation (put character, read
// cell, clear screen) with its character and read coordinates. Every request
// gives exactly one result on out_ch: the read cell (zero unless a read hits
// the screen) and the cursor position after the request.
// A carriage return, line feed, clear, unused code, read outside the screen
// or put into a row that already holds data loads the result register from
// the idle state; a read first waits in ST_READ for the registered read data.
// A put into a row that was blanked by reset, clear or scroll first sweeps
// that row with blanks in ST_FILL, one cell per cycle through the single
// write port, then writes the character in ST_PUT. One request is in flight
// at a time. Scrolling rotates a top-row offset and marks the freed row blank
// instead of sweeping it; clear resets the offset and marks all rows blank at once.
// Reset leaves every row marked blank with no sweep: requests are taken in
// the first cycle after reset. The result sits in an output register; a new
// request is taken while the old result leaves in the same cycle, and a
// stalled receiver holds off new requests.
module text_terminal_writer import ttw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic clk,
  input  logic rst_n,
  ttw_in_if.sink    in_ch,
  ttw_out_if.source out_ch
);

  localparam int RW        = $clog2(SCREEN_ROWS);
  localparam int CW        = $clog2(SCREEN_COLS);
  localparam int NUM_CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW        = $clog2(NUM_CELLS);
  localparam logic [RW:0]   ROWS_EXT = (RW + 1)'(SCREEN_ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= ROWS_EXT) begin
      sum = sum - ROWS_EXT;
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow * SCREEN_COLS) + AW'(col);
  endfunction

  state_t                 st_r, st_nxt;
  logic [RW-1:0]          cur_row_r, cur_row_nxt;
  logic [CW-1:0]          cur_col_r, cur_col_nxt;
  logic [RW-1:0]          top_r, top_nxt;
  logic [SCREEN_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [CW-1:0]          fill_col_r, fill_col_nxt;
  logic [CHAR_W-1:0]      pend_char_r, pend_char_nxt;
  logic                   rd_hit_r, rd_hit_nxt;
  logic                   out_vld_r, out_vld_nxt;
  cell_t                  out_cell_r, out_cell_nxt;
  logic [ROW_W-1:0]       out_row_r;
  logic [COL_W-1:0]       out_col_r;

  logic                   accept;
  logic                   out_load;
  logic                   do_put;
  logic                   do_newline;
  logic [CHAR_W-1:0]      put_char;
  logic [RW-1:0]          cur_prow;
  logic [RW-1:0]          rd_prow;
  logic                   rd_in_range;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  cell_t                  mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  cell_t                  mem_rdata;

  ttw_cell_mem #(.DEPTH(NUM_CELLS)) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register frees up in the same cycle that its result leaves.
  assign in_ch.ready = (st_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign cur_prow    = phys_row(cur_row_r, top_r);
  assign rd_prow     = phys_row(RW'(in_ch.read_row), top_r);
  assign rd_in_range = (32'(in_ch.read_row) < 32'(SCREEN_ROWS)) &&
                       (32'(in_ch.read_col) < 32'(SCREEN_COLS));

  always_comb begin
    st_nxt        = st_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    row_valid_nxt = row_valid_r;
    fill_col_nxt  = fill_col_r;
    pend_char_nxt = pend_char_r;
    rd_hit_nxt    = rd_hit_r;
    out_cell_nxt  = '0;
    out_load      = 1'b0;
    do_put        = 1'b0;
    do_newline    = 1'b0;
    put_char      = pend_char_r;
    mem_we        = 1'b0;
    mem_waddr     = cell_addr(cur_prow, cur_col_r);
    mem_wdata     = BLANK_CELL;
    mem_re        = 1'b0;
    mem_raddr     = cell_addr(rd_prow, CW'(in_ch.read_col));

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          pend_char_nxt = in_ch.character;
          case (in_ch.operation)
            OP_PUT: begin
              if (in_ch.character == CH_CR) begin
                cur_col_nxt = '0;
                out_load    = 1'b1;
              end else if (in_ch.character == CH_LF) begin
                do_newline = 1'b1;
                out_load   = 1'b1;
              end else if (row_valid_r[cur_prow]) begin
                do_put   = 1'b1;
                put_char = in_ch.character;
              end else begin
                // The row still holds stale cells: blank it before writing.
                fill_col_nxt = '0;
                st_nxt       = ST_FILL;
              end
            end
            OP_READ: begin
              if (rd_in_range) begin
                mem_re     = 1'b1;
                rd_hit_nxt = row_valid_r[rd_prow];
                st_nxt     = ST_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_CLEAR: begin
              cur_row_nxt   = '0;
              cur_col_nxt   = '0;
              top_nxt       = '0;
              row_valid_nxt = '0;
              out_load      = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(cur_prow, fill_col_r);
        if (fill_col_r == LAST_COL) begin
          row_valid_nxt[cur_prow] = 1'b1;
          st_nxt                  = ST_PUT;
        end else begin
          fill_col_nxt = fill_col_r + CW'(1);
        end
      end
      ST_PUT: begin
        do_put = 1'b1;
      end
      ST_READ: begin
        out_cell_nxt = rd_hit_r ? mem_rdata : BLANK_CELL;
        out_load     = 1'b1;
        st_nxt       = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (do_put) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(cur_prow, cur_col_r);
      mem_wdata = '{attr: ATTR_DEFAULT, chr: put_char};
      out_load  = 1'b1;
      st_nxt    = ST_IDLE;
      if (cur_col_r == LAST_COL) begin
        do_newline = 1'b1;
      end else begin
        cur_col_nxt = cur_col_r + CW'(1);
      end
    end

    if (do_newline) begin
      cur_col_nxt = '0;
      if (cur_row_r == LAST_ROW) begin
        // Scroll: the old top row becomes the blank bottom row.
        row_valid_nxt[top_r] = 1'b0;
        top_nxt              = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
      end else begin
        cur_row_nxt = cur_row_r + RW'(1);
      end
    end

    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      row_valid_r <= '0;
      fill_col_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      row_valid_r <= row_valid_nxt;
      fill_col_r  <= fill_col_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_char_r <= pend_char_nxt;
    rd_hit_r    <= rd_hit_nxt;
    if (out_load) begin
      out_cell_r <= out_cell_nxt;
      out_row_r  <= ROW_W'(cur_row_nxt);
      out_col_r  <= COL_W'(cur_col_nxt);
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.cell_char  = out_cell_r.chr;
  assign out_ch.cell_attr  = out_cell_r.attr;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_col = out_col_r;

endmodule

>>> sv/ttw_cell_mem.sv
// Screen cell store of the text terminal writer: one write port and one read
// port with registered read data. Depends on ttw_pkg for the cell type.
module ttw_cell_mem import ttw_pkg::*; #(
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cell_t                    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output cell_t                    rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/text_terminal_writer_test.sv
// Self-checking bench for the text terminal writer: random and directed console requests
// checked against an in-bench model of the screen, cursor and scroll offset.
// Depends on ttw_pkg, ttw_if and text_terminal_writer.
module text_terminal_writer_test;
  import ttw_pkg::*;

  localparam int SCREEN_COLS   = 80;
  localparam int SCREEN_ROWS   = 25;
  localparam int NUM_CELLS     = SCREEN_COLS * SCREEN_ROWS;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int MAX_WAIT      = 11;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    bit                drain_first;
  } request_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } reply_t;

  logic clk;
  logic rst_n;

  ttw_in_if  in_ch ();
  ttw_out_if out_ch ();

  text_terminal_writer #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Console model: the screen store, the cursor and the top-row offset.
  cell_t screen [NUM_CELLS];
  int    cur_row;
  int    cur_col;
  int    top_off;

  request_t typed_requests[$];
  reply_t   due_replies[$];
  request_t offered;

  int send_gap;
  int stall_left;
  int n_sent;
  int n_results;
  int errors;
  int cycles;
  bit quiet_sender;
  bit quiet_receiver;

  function automatic int cell_index(int lrow, int col);
    return ((lrow + top_off) % SCREEN_ROWS) * SCREEN_COLS + col;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < NUM_CELLS; i++) screen[i] = BLANK_CELL;
    cur_row = 0;
    cur_col = 0;
    top_off = 0;
  endfunction

  // Leaving the last row blanks the logical top row, which becomes the new bottom row.
  function automatic void advance_line();
    cur_col = 0;
    if (cur_row + 1 < SCREEN_ROWS) begin
      cur_row++;
    end else begin
      for (int c = 0; c < SCREEN_COLS; c++) screen[cell_index(0, c)] = BLANK_CELL;
      top_off = (top_off + 1) % SCREEN_ROWS;
      cur_row = SCREEN_ROWS - 1;
    end
  endfunction

  function automatic reply_t console_apply(request_t rq);
    reply_t rp;
    cell_t  rd_cell;
    rp = '0;
    case (rq.op)
      OP_PUT: begin
        if (rq.ch == CH_CR) begin
          cur_col = 0;
        end else if (rq.ch == CH_LF) begin
          advance_line();
        end else begin
          screen[cell_index(cur_row, cur_col)] = '{attr: ATTR_DEFAULT, chr: rq.ch};
          cur_col++;
          if (cur_col >= SCREEN_COLS) advance_line();
        end
      end
      OP_READ: begin
        if (rq.row < SCREEN_ROWS && rq.col < SCREEN_COLS) begin
          rd_cell = screen[cell_index(rq.row, rq.col)];
          rp.cell_char = rd_cell.chr;
          rp.cell_attr = rd_cell.attr;
        end
      end
      OP_CLEAR: blank_screen();
      default: ;
    endcase
    rp.cursor_row = cur_row[ROW_W-1:0];
    rp.cursor_col = cur_col[COL_W-1:0];
    return rp;
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                               bit drain_first = 1'b0);
    request_t rq;
    rq.op          = op;
    rq.ch          = ch;
    rq.row         = row;
    rq.col         = col;
    rq.drain_first = drain_first;
    typed_requests.push_back(rq);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sender: one request at a time from the queue, with a random gap after each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= OP_PUT;
      in_ch.character <= '0;
      in_ch.read_row  <= '0;
      in_ch.read_col  <= '0;
      send_gap = 0;
      blank_screen();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_replies.push_back(console_apply(offered));
        n_sent++;
        if (n_sent % 64 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
        send_gap = quiet_sender ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (typed_requests.size() > 0 &&
                     !(typed_requests[0].drain_first && due_replies.size() > 0)) begin
          offered = typed_requests.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.operation <= offered.op;
          in_ch.character <= offered.ch;
          in_ch.read_row  <= offered.row;
          in_ch.read_col  <= offered.col;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction, then stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: char %h attr %h row %0d col %0d",
                     out_ch.cell_char, out_ch.cell_attr, out_ch.cursor_row,
                     out_ch.cursor_col);
        end else begin
          if (out_ch.cell_char !== due_replies[0].cell_char ||
              out_ch.cell_attr !== due_replies[0].cell_attr ||
              out_ch.cursor_row !== due_replies[0].cursor_row ||
              out_ch.cursor_col !== due_replies[0].cursor_col) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected char %h attr %h row %0d col %0d, got %h %h %0d %0d",
                       n_results, due_replies[0].cell_char, due_replies[0].cell_attr,
                       due_replies[0].cursor_row, due_replies[0].cursor_col,
                       out_ch.cell_char, out_ch.cell_attr, out_ch.cursor_row,
                       out_ch.cursor_col);
          end
          void'(due_replies.pop_front());
        end
        n_results++;
        if (n_results % 64 == 0) quiet_receiver = ($urandom_range(0, 3) == 0);
        stall_left = quiet_receiver ? 0 : $urandom_range(0, MAX_WAIT);
        // Long hold-offs let the sender back up against a full block.
        if (n_results == 300 || n_results == 1000) stall_left = LONG_HOLD;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    int r;
    int lf_pct;
    logic [CHAR_W-1:0] ch;

    // Directed: blank reads at the corners, reads just off the screen, byte extremes,
    // return, line feed, the unused code and a clear.
    queue_request(OP_READ, 8'h00, 5'd0, 7'd0);
    queue_request(OP_READ, 8'hFF, 5'd24, 7'd79);
    queue_request(OP_READ, 8'h00, 5'd25, 7'd0);
    queue_request(OP_READ, 8'h00, 5'd0, 7'd80);
    queue_request(OP_READ, 8'hFF, 5'd31, 7'd127);
    queue_request(OP_PUT, 8'h41, 5'd31, 7'd127);
    queue_request(OP_PUT, 8'hFF, 5'd0, 7'd0);
    queue_request(OP_PUT, 8'h00, 5'd0, 7'd0);
    queue_request(OP_PUT, CH_CR, 5'd0, 7'd0);
    queue_request(OP_PUT, 8'h7A, 5'd0, 7'd0);
    queue_request(OP_PUT, CH_LF, 5'd31, 7'd127);
    queue_request(OP_PUT, 8'h20, 5'd0, 7'd0);
    queue_request(OP_READ, 8'h00, 5'd0, 7'd0);
    queue_request(OP_READ, 8'h00, 5'd0, 7'd1);
    queue_request(OP_READ, 8'h00, 5'd0, 7'd2);
    queue_request(OP_READ, 8'h00, 5'd1, 7'd0);
    queue_request(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
    queue_request(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
    queue_request(OP_READ, 8'h00, 5'd0, 7'd0);
    queue_request(OP_PUT, 8'h55, 5'd0, 7'd0);
    queue_request(OP_READ, 8'h00, 5'd0, 7'd0, 1'b1);

    // Random: mostly text with line feeds, so the cursor reaches the bottom and scrolls.
    // Long-line stretches make the cursor wrap, on the last row too.
    lf_pct = 12;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) lf_pct = ($urandom_range(0, 2) == 0) ? 1 : 14;
      r = $urandom_range(0, 299);
      if (r == 0) begin
        queue_request(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          r = $urandom_range(0, 99);
          if (r < lf_pct) ch = CH_LF;
          else if (r < lf_pct + 3) ch = CH_CR;
          else ch = CHAR_W'($urandom_range(0, 255));
          queue_request(OP_PUT, ch, ROW_W'($urandom_range(0, 31)),
                        COL_W'($urandom_range(0, 127)), i == 600);
        end else if (r < 90) begin
          queue_request(OP_READ, CHAR_W'($urandom_range(0, 255)),
                        ROW_W'($urandom_range(0, SCREEN_ROWS - 1)),
                        COL_W'($urandom_range(0, SCREEN_COLS - 1)));
        end else if (r < 96) begin
          queue_request(OP_READ, CHAR_W'($urandom_range(0, 255)),
                        ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
        end else begin
          queue_request(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                        ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
        end
      end
    end

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (typed_requests.size() > 0 || in_ch.valid) @(posedge clk);
    while (due_replies.size() > 0) @(posedge clk);
    repeat (2 * SCREEN_COLS) @(posedge clk);

    if (errors == 0 && due_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ttw_pkg.sv
sv/ttw_if.sv
sv/ttw_cell_mem.sv
sv/text_terminal_writer.sv
tb/text_terminal_writer_test.sv
